// ===== hdl/tuv_pkg.sv =====
// ----------------------------------------------------------------------------
// tuv_pkg
// Shared types, constants and the utf-8 byte rule for the trimmed text
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package tuv_pkg;

   // capacity and field widths
   localparam int unsigned CAP_W        = 11;
   localparam int unsigned CapacityMax  = 1024;
   localparam logic [CAP_W-1:0] CAPACITY_MAX = CAP_W'(CapacityMax);
   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);
   localparam int unsigned OFFSET_W     = 16;
   localparam int unsigned LENGTH_W     = 10;

   // byte constants
   localparam logic [7:0] BYTE_TERM  = 8'h00;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_CR    = 8'h0d;
   localparam logic [7:0] BYTE_LF    = 8'h0a;
   localparam logic [7:0] BYTE_DEL   = 8'h7f;

   // configuration register indexes
   localparam logic REG_CAPACITY = 1'b0;

   // bound on the second byte of a multibyte sequence
   typedef enum logic [2:0] {
      RULE_NONE = 3'd0,
      RULE_E0   = 3'd1,
      RULE_ED   = 3'd2,
      RULE_F0   = 3'd3,
      RULE_F4   = 3'd4
   } rule_type;

   // outcome of checking one content byte
   typedef struct packed {
      logic       ok;
      logic [1:0] cont;
      rule_type   rule;
   } utf8_step_type;

   // one result item
   typedef struct packed {
      logic [LENGTH_W-1:0] trimmed_length;
      logic [OFFSET_W-1:0] start_offset;
      logic                accepted;
   } result_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_CR) || (b == BYTE_LF);
   endfunction

   // check one content byte given the pending sequence state
   function automatic utf8_step_type utf8_check(input logic [7:0] b,
                                                input logic [1:0] cont,
                                                input rule_type   rule);
      utf8_step_type r;
      logic [7:0]    lo;
      logic [7:0]    hi;
      r.ok   = 1'b1;
      r.cont = cont;
      r.rule = rule;
      lo     = 8'h80;
      hi     = 8'hbf;
      if (cont != 2'd0) begin
         case (rule)
            RULE_E0: lo = 8'ha0;
            RULE_ED: hi = 8'h9f;
            RULE_F0: lo = 8'h90;
            RULE_F4: hi = 8'h8f;
            default: ;
         endcase
         r.rule = RULE_NONE;
         if ((b < lo) || (b > hi)) begin
            r.ok = 1'b0;
         end else begin
            r.cont = cont - 2'd1;
         end
      end else begin
         case (b) inside
            [8'h00:8'h7f]: r.ok = (b >= BYTE_SPACE) && (b != BYTE_DEL);
            [8'hc2:8'hdf]: r.cont = 2'd1;
            [8'he0:8'hef]: begin
               r.cont = 2'd2;
               if (b == 8'he0) begin
                  r.rule = RULE_E0;
               end else if (b == 8'hed) begin
                  r.rule = RULE_ED;
               end
            end
            [8'hf0:8'hf4]: begin
               r.cont = 2'd3;
               if (b == 8'hf0) begin
                  r.rule = RULE_F0;
               end else if (b == 8'hf4) begin
                  r.rule = RULE_F4;
               end
            end
            default: r.ok = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tuv_csr.sv =====
// ----------------------------------------------------------------------------
// tuv_csr
// Configuration register file: holds the destination buffer capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module tuv_csr import tuv_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output logic      [CAP_W-1:0] capacity
);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             wr_cap;

   // write decode
   assign wr_cap = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_CAPACITY);
   assign capacity_in = wr_cap ? csr_pwdata[CAP_W-1:0] : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_CAPACITY) begin
         csr_prdata = {{(32-CAP_W){1'b0}}, capacity_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign capacity   = capacity_ff;

endmodule

`default_nettype wire

// ===== hdl/tuv_step.sv =====
// ----------------------------------------------------------------------------
// tuv_step
// Per-string scan state and its one-byte update: leading skip, trailing
// whitespace hold-back, length check and utf-8 sequence tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module tuv_step import tuv_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_valid,
   input  wire logic [7:0]       text_byte,
   input  wire logic [CAP_W-1:0] capacity,
   output result_type            result
);

   logic                in_lead_ff,   in_lead_in;
   logic                failed_ff,    failed_in;
   logic [1:0]          cont_ff,      cont_in;
   rule_type            rule_ff,      rule_in;
   logic [CAP_W-1:0]    trail_ff,     trail_in;
   logic                ctrl_ff,      ctrl_in;
   logic [CAP_W-1:0]    body_ff,      body_in;
   logic [OFFSET_W-1:0] lead_cnt_ff,  lead_cnt_in;

   logic [CAP_W-1:0]    cap_eff;
   logic [CAP_W:0]      used_sum;
   logic [CAP_W-1:0]    body_base;
   logic                is_term;
   logic                byte_space;
   logic                ok;
   utf8_step_type       chk;

   assign cap_eff    = (capacity > CAPACITY_MAX) ? CAPACITY_MAX : capacity;
   assign is_term    = (text_byte == BYTE_TERM);
   assign byte_space = is_space(text_byte);
   assign used_sum   = {1'b0, body_ff} + {1'b0, trail_ff} + (CAP_W+1)'(1);
   assign body_base  = body_ff + trail_ff;
   assign chk        = utf8_check(text_byte, cont_ff, rule_ff);

   // result for a terminator, from the state before it
   assign ok = !failed_ff && (cap_eff != '0) && (body_ff != '0) && (cont_ff == 2'd0);
   assign result.accepted       = ok;
   assign result.start_offset   = lead_cnt_ff;
   assign result.trimmed_length = ok ? body_ff[LENGTH_W-1:0] : '0;

   // next state for one byte
   always_comb begin
      in_lead_in  = in_lead_ff;
      failed_in   = failed_ff;
      cont_in     = cont_ff;
      rule_in     = rule_ff;
      trail_in    = trail_ff;
      ctrl_in     = ctrl_ff;
      body_in     = body_ff;
      lead_cnt_in = lead_cnt_ff;
      if (is_term) begin
         in_lead_in  = 1'b1;
         failed_in   = 1'b0;
         cont_in     = 2'd0;
         rule_in     = RULE_NONE;
         trail_in    = '0;
         ctrl_in     = 1'b0;
         body_in     = '0;
         lead_cnt_in = '0;
      end else if (in_lead_ff && byte_space) begin
         if (lead_cnt_ff != '1) begin
            lead_cnt_in = lead_cnt_ff + OFFSET_W'(1);
         end
      end else begin
         in_lead_in = 1'b0;
         if (!failed_ff) begin
            if (used_sum >= {1'b0, cap_eff}) begin
               failed_in = 1'b1;
            end else if (byte_space) begin
               if (cont_ff != 2'd0) begin
                  failed_in = 1'b1;
               end else begin
                  trail_in = trail_ff + CAP_W'(1);
                  ctrl_in  = ctrl_ff || (text_byte != BYTE_SPACE);
               end
            end else if ((trail_ff != '0) && ctrl_ff) begin
               failed_in = 1'b1;
            end else begin
               // held-back spaces become content, then check the byte
               trail_in = '0;
               cont_in  = chk.cont;
               rule_in  = chk.rule;
               if (chk.ok) begin
                  body_in = body_base + CAP_W'(1);
               end else begin
                  body_in   = body_base;
                  failed_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_lead_ff  <= 1'b1;
         failed_ff   <= 1'b0;
         cont_ff     <= 2'd0;
         rule_ff     <= RULE_NONE;
         trail_ff    <= '0;
         ctrl_ff     <= 1'b0;
         body_ff     <= '0;
         lead_cnt_ff <= '0;
      end else if (step_valid) begin
         in_lead_ff  <= in_lead_in;
         failed_ff   <= failed_in;
         cont_ff     <= cont_in;
         rule_ff     <= rule_in;
         trail_ff    <= trail_in;
         ctrl_ff     <= ctrl_in;
         body_ff     <= body_in;
         lead_cnt_ff <= lead_cnt_in;
      end
   end

`ifndef ASSERT_OFF
   // a terminator leaves the scan state cleared
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (step_valid && is_term) |=> (in_lead_ff && !failed_ff && (body_ff == '0)
                                   && (trail_ff == '0) && (lead_cnt_ff == '0)))
      else $error("scan state not cleared after terminator");

   // a second-byte bound is only pending at the start of a long sequence
   a_rule_cont: assert property (@(posedge clock) disable iff (reset)
      (rule_ff != RULE_NONE) |-> (cont_ff >= 2'd2))
      else $error("second-byte rule pending without a sequence");

   // held-back whitespace never sits inside a sequence
   a_trail_cont: assert property (@(posedge clock) disable iff (reset)
      (trail_ff != '0) |-> (cont_ff == 2'd0))
      else $error("trailing whitespace inside a multibyte sequence");
`endif

endmodule

`default_nettype wire

// ===== hdl/trimmed_utf8_text_validator.sv =====
// a terminator request is held in the input register, then its result in the result register
// throughput: one request per cycle, set by the scan state update, unless a terminator waits
// a terminator waits only while the result register holds an untaken result
// reset: synchronous, clears the scan state and sets the capacity to 64
// no clearing pass after reset; the block takes requests in the next cycle
// ----------------------------------------------------------------------------
// trimmed_utf8_text_validator
// Checks a zero-terminated byte stream as trimmed, visible utf-8 text and
// reports acceptance, leading skip count and trimmed length per string.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_utf8_text_validator import tuv_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: text_byte [7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // result: accepted [0], start_offset [16:1], trimmed_length [26:17]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic             req_valid_ff, req_valid_in;
   logic [7:0]       req_byte_ff,  req_byte_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff,  rsp_data_in;
   logic [CAP_W-1:0] capacity;
   result_type       result;
   logic             is_term;
   logic             proceed;

   tuv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   tuv_step u_step (
      .clock      (clock),
      .reset      (reset),
      .step_valid (proceed),
      .text_byte  (req_byte_ff),
      .capacity   (capacity),
      .result     (result)
   );

   // the held byte moves on unless it is a terminator facing a full result
   assign is_term    = (req_byte_ff == BYTE_TERM);
   assign proceed    = req_valid_ff && (!is_term || !rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || proceed;

   // input register
   assign req_valid_in = req_tready ? req_tvalid : req_valid_ff;
   assign req_byte_in  = (req_tvalid && req_tready) ? req_tdata : req_byte_ff;

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (proceed && is_term) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_byte_ff <= req_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32-$bits(result_type)){1'b0}}, rsp_data_ff};

`ifndef ASSERT_OFF
   // only a terminator can hold up the request side
   a_stall_term: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !req_tready) |-> (is_term && rsp_valid_ff && !rsp_tready))
      else $error("request stalled on a byte that gives no result");

   // a rejected string reports zero length
   a_reject_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.accepted) |-> (rsp_data_ff.trimmed_length == '0))
      else $error("rejected string with nonzero length");

   // a waiting result stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("waiting result dropped or changed");
`endif

endmodule

`default_nettype wire
